/* src/wafp_pkg.sv */
// Shared constants for the windowed average fee policy block.
package wafp_pkg;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned SAMPLE_BITS  = 32;

  localparam int unsigned ADDR_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned COUNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + ADDR_BITS;
  localparam int unsigned STEP_BITS  = $clog2(SUM_BITS);

  localparam int unsigned FLOOR_BITS = 6;
  localparam int unsigned BIAS_BITS  = 14;
  localparam int unsigned IN_BYTES   = (2 * SAMPLE_BITS + 7) / 8;
  localparam int unsigned OUT_BYTES  = (FLOOR_BITS + BIAS_BITS + 7) / 8;

  // Average pool size tier thresholds (strictly above; POOL_LOW is strictly below)
  localparam int unsigned POOL_TIER_4 = 1500;
  localparam int unsigned POOL_TIER_3 = 800;
  localparam int unsigned POOL_TIER_2 = 400;
  localparam int unsigned POOL_TIER_1 = 150;
  localparam int unsigned POOL_LOW    = 40;

  localparam int unsigned BONUS_4 = 25;
  localparam int unsigned BONUS_3 = 14;
  localparam int unsigned BONUS_2 = 8;
  localparam int unsigned BONUS_1 = 4;

  localparam int unsigned BIAS_4   = 9800;
  localparam int unsigned BIAS_3   = 9900;
  localparam int unsigned BIAS_2   = 9950;
  localparam int unsigned BIAS_MID = 10000;
  localparam int unsigned BIAS_LOW = 10100;

  // Fee term: avg_fee / 50, capped at 32. At or above 32 * 50 the cap applies.
  localparam int unsigned FEE_DIV       = 50;
  localparam int unsigned FEE_CAP       = 32;
  localparam int unsigned FEE_CAP_START = FEE_CAP * FEE_DIV;
  localparam int unsigned FEE_IN_BITS   = $clog2(FEE_CAP_START);
  // x / 50 == (x * 1311) >> 16 for every x below the cap start
  localparam int unsigned FEE_RECIP       = 1311;
  localparam int unsigned FEE_RECIP_BITS  = 11;
  localparam int unsigned FEE_RECIP_SHIFT = 16;
  localparam int unsigned FEE_PROD_BITS   = FEE_IN_BITS + FEE_RECIP_BITS;

endpackage

/* src/wafp_ram.sv */
// Generic single-port-write, registered-read RAM.
module wafp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]              wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/windowed_average_fee_policy.sv */
// Windowed average fee policy: 64-deep sample window, averages, fee floor and bias.
// The window slot is read at the accept edge, followed by an evict and sum update state,
//   38 bit-serial divider steps by the fill count and a policy state that waits for the output register.
// Input is taken only while idle, so one item is in work at a time; a finished item may
//   wait in the output register while the next one is taken.
// Reset: slot, fill count, sums and control clear at once; the window RAM is not
module windowed_average_fee_policy (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] pool_size_sample, [63:32] fee_sample
  input  logic [8*wafp_pkg::IN_BYTES-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] min_fee, [19:6] bias_bps, [23:20] zero
  output logic [8*wafp_pkg::OUT_BYTES-1:0] m_axis_tdata
);

  // The window RAM is not cleared: an entry is only read back for eviction
  // after it was written.

  localparam int unsigned SB = wafp_pkg::SAMPLE_BITS;
  localparam int unsigned AB = wafp_pkg::ADDR_BITS;
  localparam int unsigned CB = wafp_pkg::COUNT_BITS;
  localparam int unsigned UB = wafp_pkg::SUM_BITS;
  localparam int unsigned TB = wafp_pkg::STEP_BITS;
  localparam int unsigned FB = wafp_pkg::FLOOR_BITS;
  localparam int unsigned BB = wafp_pkg::BIAS_BITS;
  localparam int unsigned OW = 8 * wafp_pkg::OUT_BYTES;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [AB-1:0]   slot_q, slot_d;
  logic [CB-1:0]   fill_cnt_q, fill_cnt_d;
  logic [UB-1:0]   pool_sum_q, pool_sum_d;
  logic [UB-1:0]   fee_sum_q, fee_sum_d;
  logic [TB-1:0]   step_q, step_d;
  logic            out_valid_q, out_valid_d;

  // payload registers
  logic [SB-1:0]   pool_in_q, fee_in_q;
  logic [UB-1:0]   div_pool_q, div_pool_d;
  logic [UB-1:0]   div_fee_q, div_fee_d;
  logic [CB-1:0]   rem_pool_q, rem_pool_d;
  logic [CB-1:0]   rem_fee_q, rem_fee_d;
  logic [OW-1:0]   out_data_q, out_data_d;

  logic            in_fire;
  logic            win_full;
  logic [2*SB-1:0] ram_rdata;
  logic [SB-1:0]   old_pool, old_fee;
  logic            ram_we;

  // divider trial subtracts
  logic [CB:0]     trial_pool, trial_fee;
  logic            qbit_pool, qbit_fee;

  // policy
  logic [FB-1:0]   bonus;
  logic [BB-1:0]   bias;
  logic [FB-1:0]   fee_term;
  logic [wafp_pkg::FEE_PROD_BITS-1:0] fee_prod;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign win_full  = (fill_cnt_q == CB'(wafp_pkg::WINDOW_DEPTH));
  assign ram_we    = (state_q == ST_EVICT);
  assign old_pool  = ram_rdata[SB-1:0];
  assign old_fee   = ram_rdata[2*SB-1:SB];

  // Window store: {fee, pool} per slot. Read the slot in the accept cycle,
  // overwrite it in the cycle after.
  wafp_ram #(
    .Width (2 * SB),
    .Depth (wafp_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({fee_in_q, pool_in_q}),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // One restoring step on each dividend: shift in the top bit, try the count.
  assign trial_pool = {rem_pool_q, div_pool_q[UB-1]};
  assign trial_fee  = {rem_fee_q, div_fee_q[UB-1]};
  assign qbit_pool  = (trial_pool >= {1'b0, fill_cnt_q});
  assign qbit_fee   = (trial_fee >= {1'b0, fill_cnt_q});

  // Policy on the finished quotients.
  always_comb begin
    if (div_pool_q > UB'(wafp_pkg::POOL_TIER_4)) begin
      bonus = FB'(wafp_pkg::BONUS_4);
      bias  = BB'(wafp_pkg::BIAS_4);
    end else if (div_pool_q > UB'(wafp_pkg::POOL_TIER_3)) begin
      bonus = FB'(wafp_pkg::BONUS_3);
      bias  = BB'(wafp_pkg::BIAS_3);
    end else if (div_pool_q > UB'(wafp_pkg::POOL_TIER_2)) begin
      bonus = FB'(wafp_pkg::BONUS_2);
      bias  = BB'(wafp_pkg::BIAS_2);
    end else if (div_pool_q > UB'(wafp_pkg::POOL_TIER_1)) begin
      bonus = FB'(wafp_pkg::BONUS_1);
      bias  = BB'(wafp_pkg::BIAS_MID);
    end else if (div_pool_q < UB'(wafp_pkg::POOL_LOW)) begin
      bonus = '0;
      bias  = BB'(wafp_pkg::BIAS_LOW);
    end else begin
      bonus = '0;
      bias  = BB'(wafp_pkg::BIAS_MID);
    end
  end

  // Divide by 50 through the reciprocal; cap the term at 32.
  assign fee_prod = wafp_pkg::FEE_PROD_BITS'(div_fee_q[wafp_pkg::FEE_IN_BITS-1:0])
                  * wafp_pkg::FEE_PROD_BITS'(wafp_pkg::FEE_RECIP);
  always_comb begin
    if (div_fee_q >= UB'(wafp_pkg::FEE_CAP_START)) begin
      fee_term = FB'(wafp_pkg::FEE_CAP);
    end else begin
      fee_term = FB'(fee_prod >> wafp_pkg::FEE_RECIP_SHIFT);
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    fill_cnt_d  = fill_cnt_q;
    pool_sum_d  = pool_sum_q;
    fee_sum_d   = fee_sum_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    div_pool_d  = div_pool_q;
    div_fee_d   = div_fee_q;
    rem_pool_d  = rem_pool_q;
    rem_fee_d   = rem_fee_q;
    out_data_d  = out_data_q;

    // drop the output item once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        // evict the oldest pair when full, else grow the window
        if (win_full) begin
          pool_sum_d = pool_sum_q - UB'(old_pool) + UB'(pool_in_q);
          fee_sum_d  = fee_sum_q - UB'(old_fee) + UB'(fee_in_q);
        end else begin
          pool_sum_d = pool_sum_q + UB'(pool_in_q);
          fee_sum_d  = fee_sum_q + UB'(fee_in_q);
          fill_cnt_d = fill_cnt_q + CB'(1);
        end
        if (slot_q == AB'(wafp_pkg::WINDOW_DEPTH - 1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + AB'(1);
        end
        div_pool_d = pool_sum_d;
        div_fee_d  = fee_sum_d;
        rem_pool_d = '0;
        rem_fee_d  = '0;
        step_d     = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        rem_pool_d = qbit_pool ? CB'(trial_pool - {1'b0, fill_cnt_q}) : CB'(trial_pool);
        rem_fee_d  = qbit_fee ? CB'(trial_fee - {1'b0, fill_cnt_q}) : CB'(trial_fee);
        div_pool_d = {div_pool_q[UB-2:0], qbit_pool};
        div_fee_d  = {div_fee_q[UB-2:0], qbit_fee};
        step_d     = step_q + TB'(1);
        if (step_q == TB'(UB - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OW'({bias, FB'(FB'(1) + bonus + fee_term)});
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      fill_cnt_q  <= '0;
      pool_sum_q  <= '0;
      fee_sum_q   <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_cnt_q  <= fill_cnt_d;
      pool_sum_q  <= pool_sum_d;
      fee_sum_q   <= fee_sum_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pool_in_q <= s_axis_tdata[SB-1:0];
      fee_in_q  <= s_axis_tdata[2*SB-1:SB];
    end
    div_pool_q <= div_pool_d;
    div_fee_q  <= div_fee_d;
    rem_pool_q <= rem_pool_d;
    rem_fee_q  <= rem_fee_d;
    out_data_q <= out_data_d;
  end

  // Fill count never passes the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q <= CB'(wafp_pkg::WINDOW_DEPTH))
    else $error("fill count above window depth");

  // The divisor is never zero while dividing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (fill_cnt_q != '0))
    else $error("divide by empty window");

  // Partial remainders stay below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((rem_pool_q < fill_cnt_q) && (rem_fee_q < fill_cnt_q)))
    else $error("divider remainder out of range");

  // A new output item only comes out of the policy step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("output valid without finished item");

endmodule

/* tb/sv/testbench.sv */
// Self-checking stream testbench: windowed fee policy checked against a local window predictor.
`timescale 1ns / 1ps

module testbench;
  import wafp_pkg::*;

  localparam int unsigned IN_W         = 8 * IN_BYTES;
  localparam int unsigned OUT_W        = 8 * OUT_BYTES;
  localparam int unsigned BIAS_LSB     = FLOOR_BITS;
  localparam int unsigned PAD_LSB      = FLOOR_BITS + BIAS_BITS;
  localparam int unsigned RANDOM_ITEMS = 1750;
  // Give the block far longer than one item takes before giving up.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 60;

  // One sample pair on its way to the block; drain holds it back until all
  // outstanding results have come out.
  typedef struct {
    logic [SAMPLE_BITS-1:0] pool;
    logic [SAMPLE_BITS-1:0] fee;
    bit                     drain;
  } sample_pair_t;

  typedef struct {
    logic [FLOOR_BITS-1:0] min_fee;
    logic [BIAS_BITS-1:0]  bias_bps;
  } fee_policy_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // [31:0] pool_size_sample, [63:32] fee_sample
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // [5:0] min_fee, [19:6] bias_bps, [23:20] zero
  logic [OUT_W-1:0] m_axis_tdata;

  windowed_average_fee_policy dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the sample window, fill level and sums.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] pool_hist [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] fee_hist  [WINDOW_DEPTH];
  logic [ADDR_BITS-1:0]   next_slot    = '0;
  logic [COUNT_BITS-1:0]  samples_held = '0;
  logic [SUM_BITS-1:0]    pool_total   = '0;
  logic [SUM_BITS-1:0]    fee_total    = '0;

  sample_pair_t pending_samples [$];
  fee_policy_t  expected_policy [$];

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_gap     = 0;
  int unsigned send_calm    = 0;
  int unsigned take_stall   = 0;
  int unsigned take_calm    = 0;
  logic [4:0]  bias_levels  = '0;
  int unsigned floor_lo     = 63;
  int unsigned floor_hi     = 0;

  // Running sums for the directed part, which steers the window average onto
  // chosen values while the window is still filling.
  longint unsigned steer_count = 0;
  longint unsigned steer_pool  = 0;
  longint unsigned steer_fee   = 0;

  // Push one pair into the window copy and work out the fee floor and bias.
  function automatic fee_policy_t fee_policy_predict(logic [SAMPLE_BITS-1:0] pool,
                                                     logic [SAMPLE_BITS-1:0] fee);
    fee_policy_t         res;
    logic [SUM_BITS-1:0] avg_pool;
    logic [SUM_BITS-1:0] avg_fee;
    logic [SUM_BITS-1:0] fee_q;
    int unsigned         bonus;
    int unsigned         bias;
    int unsigned         fee_term;
    // Evict the oldest pair once the window is full; otherwise grow it.
    if (samples_held == WINDOW_DEPTH) begin
      pool_total = pool_total - pool_hist[next_slot];
      fee_total  = fee_total - fee_hist[next_slot];
    end else begin
      samples_held = samples_held + 1'b1;
    end
    pool_hist[next_slot] = pool;
    fee_hist[next_slot]  = fee;
    pool_total = pool_total + pool;
    fee_total  = fee_total + fee;
    next_slot  = (next_slot == WINDOW_DEPTH - 1) ? '0 : next_slot + 1'b1;

    avg_pool = pool_total / samples_held;
    avg_fee  = fee_total / samples_held;

    if (avg_pool > POOL_TIER_4) begin
      bonus = BONUS_4;
      bias  = BIAS_4;
    end else if (avg_pool > POOL_TIER_3) begin
      bonus = BONUS_3;
      bias  = BIAS_3;
    end else if (avg_pool > POOL_TIER_2) begin
      bonus = BONUS_2;
      bias  = BIAS_2;
    end else if (avg_pool > POOL_TIER_1) begin
      bonus = BONUS_1;
      bias  = BIAS_MID;
    end else begin
      bonus = 0;
      bias  = (avg_pool < POOL_LOW) ? BIAS_LOW : BIAS_MID;
    end

    fee_q    = avg_fee / FEE_DIV;
    fee_term = (fee_q > FEE_CAP) ? FEE_CAP : 32'(fee_q);

    res.min_fee  = FLOOR_BITS'(1 + bonus + fee_term);
    res.bias_bps = BIAS_BITS'(bias);
    return res;
  endfunction

  // Draw the wait before the next item, with runs of back-to-back items.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Queue a pair chosen so that the window averages land on the given values
  // (pool average is hit with the largest remainder the truncation allows).
  task automatic queue_average_step(input longint unsigned pool_avg,
                                    input longint unsigned fee_avg);
    sample_pair_t item;
    steer_count++;
    item.pool  = SAMPLE_BITS'(pool_avg * steer_count + steer_count - 1 - steer_pool);
    item.fee   = SAMPLE_BITS'(fee_avg * steer_count - steer_fee);
    item.drain = 1'b0;
    steer_pool += item.pool;
    steer_fee  += item.fee;
    pending_samples = {pending_samples, item};
  endtask

  task automatic queue_raw(input logic [SAMPLE_BITS-1:0] pool,
                           input logic [SAMPLE_BITS-1:0] fee);
    sample_pair_t item;
    item.pool  = pool;
    item.fee   = fee;
    item.drain = 1'b0;
    pending_samples = {pending_samples, item};
  endtask

  // Pool samples per regime: below POOL_LOW, or a band on or across a tier threshold.
  function automatic logic [SAMPLE_BITS-1:0] pool_draw(int unsigned mode);
    int unsigned edge_val;
    case (mode)
      0: return $urandom_range(0, POOL_LOW - 1);
      1: return $urandom_range(POOL_LOW, POOL_TIER_1);
      2: return $urandom_range(100, 450);
      3: return $urandom_range(350, 900);
      4: return $urandom_range(700, 1600);
      5: return $urandom_range(1400, 3000);
      6: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0:       edge_val = POOL_LOW;
          1:       edge_val = POOL_TIER_1;
          2:       edge_val = POOL_TIER_2;
          3:       edge_val = POOL_TIER_3;
          default: edge_val = POOL_TIER_4;
        endcase
        return edge_val + $urandom_range(0, 6) - 3;
      end
    endcase
  endfunction

  // Fee samples per regime: below, around and above the fee term cap.
  function automatic logic [SAMPLE_BITS-1:0] fee_draw(int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 60);
      1: return $urandom_range(0, 200);
      2: return $urandom_range(FEE_CAP_START - 150, FEE_CAP_START + 150);
      3: return $urandom_range(0, 5000);
      4: return $urandom();
      default: return FEE_DIV * $urandom_range(0, FEE_CAP + 8) + $urandom_range(0, 1) * (FEE_DIV - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued pairs, predict each one at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic            nxt_valid;
    logic [IN_W-1:0] nxt_data;
    sample_pair_t    item;
    fee_policy_t     pred;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        pred = fee_policy_predict(s_axis_tdata[SAMPLE_BITS-1:0],
                                  s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        expected_policy = {expected_policy, pred};
        items_sent++;
        nxt_valid = 1'b0;
        send_gap  = draw_wait(send_calm);
      end
      // Hold a drain-marked item until every outstanding result is back.
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() != 0 &&
                     !(pending_samples[0].drain && expected_policy.size() != 0)) begin
          item      = pending_samples[0];
          pending_samples.delete(0);
          nxt_data  = IN_W'({item.fee, item.pool});
          nxt_valid = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation, stall at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    fee_policy_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_policy.size() == 0) begin
          $error("unexpected result: tdata %h with no item outstanding", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_policy[0];
          expected_policy.delete(0);
          if (m_axis_tdata[FLOOR_BITS-1:0] !== want.min_fee) begin
            $error("min_fee mismatch: expected %0d, actual %0d",
                   want.min_fee, m_axis_tdata[FLOOR_BITS-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[PAD_LSB-1:BIAS_LSB] !== want.bias_bps) begin
            $error("bias_bps mismatch: expected %0d, actual %0d",
                   want.bias_bps, m_axis_tdata[PAD_LSB-1:BIAS_LSB]);
            mismatches++;
          end
          if (m_axis_tdata[OUT_W-1:PAD_LSB] !== '0) begin
            $error("tdata padding mismatch: expected 0, actual %h",
                   m_axis_tdata[OUT_W-1:PAD_LSB]);
            mismatches++;
          end
          case (want.bias_bps)
            BIAS_4:   bias_levels[0] = 1'b1;
            BIAS_3:   bias_levels[1] = 1'b1;
            BIAS_2:   bias_levels[2] = 1'b1;
            BIAS_MID: bias_levels[3] = 1'b1;
            default:  bias_levels[4] = 1'b1;
          endcase
          if (want.min_fee < floor_lo) floor_lo = want.min_fee;
          if (want.min_fee > floor_hi) floor_hi = want.min_fee;
        end
        take_stall = draw_wait(take_calm);
      end else if (m_axis_tvalid && take_stall > 0) begin
        // Count the stall down only while a result is waiting.
        take_stall--;
      end
      m_axis_tready <= (take_stall == 0);
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item accepted for %0d cycles", IDLE_LIMIT);
      $display("FAIL windowed_average_fee_policy");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    sample_pair_t item;
    int unsigned  queued;
    int unsigned  chunk;
    int unsigned  pool_mode;
    int unsigned  fee_mode;

    // Directed: walk the averages across every tier edge, the low-pool bias
    // and the fee cap while the window fills, then hit the field extremes.
    queue_average_step(0, 0);
    queue_average_step(POOL_LOW - 1, FEE_DIV - 1);
    queue_average_step(POOL_LOW, FEE_DIV);
    queue_average_step(POOL_TIER_1, 2 * FEE_DIV - 1);
    queue_average_step(POOL_TIER_1 + 1, 2 * FEE_DIV);
    queue_average_step(POOL_TIER_2, FEE_CAP_START - 1);
    queue_average_step(POOL_TIER_2 + 1, FEE_CAP_START);
    queue_average_step(POOL_TIER_3, FEE_CAP_START);
    queue_average_step(POOL_TIER_3 + 1, FEE_CAP_START + FEE_DIV);
    queue_average_step(POOL_TIER_4, FEE_CAP_START + FEE_DIV + 49);
    queue_average_step(POOL_TIER_4 + 1, 2000);
    queue_average_step(100000, 100000);
    queue_average_step(50000000, 300000000);
    queue_raw('1, '1);
    queue_raw('0, '1);
    queue_raw('1, '0);
    queue_raw({SAMPLE_BITS/2{2'b10}}, {SAMPLE_BITS/2{2'b01}});
    queue_raw({SAMPLE_BITS/2{2'b01}}, {SAMPLE_BITS/2{2'b10}});
    queue_raw('0, '0);

    // Random: runs of samples from one regime per field, so the window average
    // slides across thresholds; stray full-range samples mixed in.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      chunk     = $urandom_range(20, 150);
      pool_mode = $urandom_range(0, 7);
      fee_mode  = $urandom_range(0, 5);
      for (int k = 0; k < chunk && queued < RANDOM_ITEMS; k++) begin
        item.pool  = ($urandom_range(0, 49) == 0) ? $urandom() : pool_draw(pool_mode);
        item.fee   = ($urandom_range(0, 49) == 0) ? $urandom() : fee_draw(fee_mode);
        // Drain the block before the random part and now and then between runs.
        item.drain = (queued == 0) || (k == 0 && $urandom_range(0, 5) == 0);
        pending_samples = {pending_samples, item};
        queued++;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_samples.size() != 0 || s_axis_tvalid || expected_policy.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d sample pairs and %0d checked results.", items_sent, results_seen);
    $display("Bias levels seen: %0d of 5; fee floor ranged %0d to %0d.",
             $countones(bias_levels), floor_lo, floor_hi);
    if (mismatches == 0) begin
      $display("PASS windowed_average_fee_policy");
    end else begin
      $display("FAIL windowed_average_fee_policy");
    end
    $finish;
  end

endmodule

/* files.f */
src/wafp_pkg.sv
src/wafp_ram.sv
src/windowed_average_fee_policy.sv
tb/sv/testbench.sv
